FILE: rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, round constants and a helper function.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned Rounds = 64;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  valid_bytes;
		logic        final_word;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_byte;   // append byte_val at fill position
		logic [7:0] byte_val;
		logic       add_bits;    // count one message byte
		logic       start_comp;  // latch chain into working vars
		logic       do_round;
		logic [5:0] round_idx;
		logic       finish_comp; // add working vars into chain
		logic       restart;     // chain, fill and count to reset values
		logic [2:0] len_byte;    // which length byte to present
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic [7:0] len_sel;     // selected byte of the bit count
	} dp_stat_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PadByte  = 8'h80;
	localparam logic [5:0] LenStart = 6'd56;

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

endpackage

FILE: rtl/core/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial message intake with a one-round-per-cycle compression core.
// ----------------------------------------------------------------------------
// Each input beat appends its valid bytes at one byte per cycle, pausing while
// a full block is compressed. Every full 64-byte block is compressed by the
// single round unit: a latch into the working variables, 64 rounds and a chain
// update. A final beat also appends the padding bytes, one per cycle with the
// same pause, and possibly a second compression, then eight output beats of
// the digest, most significant word first. No input beat is taken until the
// digest has gone.
module sha256_stream_hasher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sha_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sha_pkg::out_item_t  out_data
);

	sha_pkg::dp_cmd_t  cmd;
	sha_pkg::dp_stat_t stat;
	logic [31:0]       chain_word [8];

	sha_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data, .cmd, .stat, .chain_word
	);

	sha_datapath u_dp (
		.clk, .arst_n, .cmd, .stat, .chain_word
	);

	// Digest words are presented in order.
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.digest_last |=>
		out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
		else $error("digest index skipped");

	// No input is taken while a digest is pending.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken during output");

	// A byte load and a round never coincide.
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_byte && cmd.do_round)) else $error("load during round");

endmodule

FILE: rtl/core/sha_datapath.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, rolling message schedule, round unit, chain value, bit count.
// ----------------------------------------------------------------------------
module sha_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sha_pkg::dp_cmd_t  cmd,
	output sha_pkg::dp_stat_t stat,
	output logic [31:0]       chain_word [8]
);

	logic [31:0] buf_q [16];
	logic [31:0] w_q   [16];
	logic [31:0] v_q   [8];
	logic [31:0] chain_q [8];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;

	logic [31:0] wt, wnew, t1, t2, s0, s1, x, y, e, a;
	logic [3:0]  widx;
	logic [4:0]  bsh;

	assign widx = fill_q[5:2];
	assign bsh  = 5'd24 - {fill_q[1:0], 3'b000};

	// Schedule word of the current round: the first sixteen come from the
	// window, later ones from the expansion of the rolling window.
	always_comb begin
		x    = w_q[1];
		y    = w_q[14];
		s0   = sha_pkg::ror(x, 7) ^ sha_pkg::ror(x, 18) ^ (x >> 3);
		s1   = sha_pkg::ror(y, 17) ^ sha_pkg::ror(y, 19) ^ (y >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
		wt   = (cmd.round_idx < 6'd16) ? w_q[0] : wnew;
		e    = v_q[4];
		a    = v_q[0];
		t1   = v_q[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
		     + ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::K[cmd.round_idx] + wt;
		t2   = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
		     + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			buf_q[widx] <= (buf_q[widx] & ~(32'hff << bsh)) | ({24'd0, cmd.byte_val} << bsh);
		end
		if (cmd.start_comp) begin
			w_q <= buf_q;
			v_q <= chain_q;
		end else if (cmd.do_round) begin
			// During the first sixteen rounds the window simply rotates.
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= sha_pkg::IV;
			fill_q  <= '0;
			bits_q  <= '0;
		end else begin
			if (cmd.load_byte) fill_q <= fill_q + 6'd1;
			if (cmd.add_bits)  bits_q <= bits_q + 64'd8;
			if (cmd.finish_comp) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
			end
			if (cmd.restart) begin
				chain_q <= sha_pkg::IV;
				fill_q  <= '0;
				bits_q  <= '0;
			end
		end
	end

	assign stat.fill    = fill_q;
	assign stat.len_sel = bits_q[{3'd7 - cmd.len_byte, 3'b000} +: 8];
	assign chain_word   = chain_q;

endmodule

FILE: rtl/core/sha_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Feeds bytes one per cycle between compressions, sequences padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sha_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sha_pkg::out_item_t  out_data,
	output sha_pkg::dp_cmd_t    cmd,
	input  sha_pkg::dp_stat_t   stat,
	input  logic [31:0]         chain_word [8]
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_BYTE = 7'b0000010,
		S_PAD  = 7'b0000100,
		S_LEN  = 7'b0001000,
		S_RND  = 7'b0010000,
		S_FIN  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [31:0] word_q;
	logic [2:0]  cnt_q;      // message bytes still to append
	logic        last_q;
	logic        padded_q;   // 0x80 already appended
	logic [2:0]  len_q;
	logic        ret_len_q;  // compression started from the length phase
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        busy_q;     // buffer full, compression latch and rounds pending

	logic [2:0] vb;
	logic       full;

	assign vb       = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;
	assign in_stall = (state_q != S_IDLE);
	assign full     = (stat.fill == 6'd63);

	always_comb begin
		cmd = '0;
		cmd.round_idx = rnd_q;
		cmd.len_byte  = len_q;
		case (state_q)
			S_BYTE: begin
				if (!busy_q) begin
					cmd.load_byte = 1'b1;
					cmd.byte_val  = word_q[31:24];
					cmd.add_bits  = 1'b1;
				end
			end
			S_PAD: begin
				if (!busy_q) begin
					cmd.load_byte = 1'b1;
					cmd.byte_val  = padded_q ? 8'h00 : sha_pkg::PadByte;
				end
			end
			S_LEN: begin
				if (!busy_q) begin
					cmd.load_byte = 1'b1;
					cmd.byte_val  = stat.len_sel;
				end
			end
			S_RND: cmd.do_round = 1'b1;
			S_FIN: cmd.finish_comp = 1'b1;
			S_OUT: cmd.restart = !out_stall && (oidx_q == 3'd7);
			default: ;
		endcase
		// A byte that fills the buffer starts a compression in the next cycle.
		if (busy_q && (state_q inside {S_BYTE, S_PAD, S_LEN}))
			cmd.start_comp = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			last_q    <= 1'b0;
			padded_q  <= 1'b0;
			len_q     <= '0;
			ret_len_q <= 1'b0;
			rnd_q     <= '0;
			oidx_q    <= '0;
			busy_q    <= 1'b0;
			word_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						word_q   <= in_data.data_word;
						cnt_q    <= vb;
						last_q   <= in_data.final_word;
						padded_q <= 1'b0;
						len_q    <= '0;
						if (vb != 3'd0)              state_q <= S_BYTE;
						else if (in_data.final_word) state_q <= S_PAD;
					end
				end
				S_BYTE, S_PAD, S_LEN: begin
					if (busy_q) begin
						busy_q <= 1'b0;
						rnd_q  <= '0;
						state_q <= S_RND;
					end else begin
						busy_q <= full;
						ret_len_q <= 1'b0;
						if (state_q == S_BYTE) begin
							word_q <= {word_q[23:0], 8'h00};
							cnt_q  <= cnt_q - 3'd1;
							if (cnt_q == 3'd1 && !full)
								state_q <= last_q ? S_PAD : S_IDLE;
						end else if (state_q == S_PAD) begin
							padded_q <= 1'b1;
							if (stat.fill == sha_pkg::LenStart - 6'd1) state_q <= S_LEN;
						end else begin
							len_q <= len_q + 3'd1;
							ret_len_q <= 1'b1;
						end
					end
				end
				S_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(sha_pkg::Rounds - 1)) state_q <= S_FIN;
				end
				S_FIN: begin
					// Resume where the filling byte left off.
					if (ret_len_q) begin
						state_q <= S_OUT;
						oidx_q  <= '0;
					end else if (cnt_q != 3'd0) state_q <= S_BYTE;
					else if (last_q) state_q <= S_PAD;
					else state_q <= S_IDLE;
				end
				S_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid            = (state_q == S_OUT);
	assign out_data.digest_word = chain_word[oidx_q];
	assign out_data.word_index  = oidx_q;
	assign out_data.digest_last = (oidx_q == 3'd7);

endmodule
